// ----- src/register_stream_frame_decoder_assert.svh -----
// Assertion macros shared by the decoder's RTL files.
// Each macro expects clk and rst_n in scope; no other dependencies.
`ifndef REGISTER_STREAM_FRAME_DECODER_ASSERT_SVH
`define REGISTER_STREAM_FRAME_DECODER_ASSERT_SVH

// condition holds at every clock out of reset
`define RSD_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// same-cycle implication
`define RSD_ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define RSD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- src/regdec_pkg.sv -----
// Shared types and constants for the register stream frame decoder.
// No dependencies; imported by every module of the block.
package regdec_pkg;

  localparam int NumRegs = 16;  // chip registers, 0..15
  localparam int ByteW   = 8;
  localparam int IdxW    = 4;
  localparam int CountW  = 9;
  localparam int KindW   = 2;
  localparam int MaskW   = 16;
  localparam int QDepth  = 2;
  localparam int QPtrW   = $clog2(QDepth);
  localparam int QCntW   = $clog2(QDepth + 1);

  localparam logic [ByteW-1:0]  CMD_EMPTY  = 8'hFF;
  localparam logic [ByteW-1:0]  CMD_SKIP   = 8'hFE;
  localparam logic [CountW-1:0] FRAME_ONE  = 9'd1;
  localparam logic [CountW-1:0] SKIP_WRAP  = 9'd256;

  typedef enum logic [1:0] {
    PH_CMD   = 2'd0,
    PH_SKIP  = 2'd1,
    PH_MASKL = 2'd2,
    PH_VALS  = 2'd3
  } phase_t;

  typedef enum logic [KindW-1:0] {
    KIND_WRITE = 2'd0,
    KIND_BOUND = 2'd1,
    KIND_END   = 2'd2
  } kind_t;

  typedef struct packed {
    kind_t               kind;
    logic [IdxW-1:0]     reg_index;
    logic [ByteW-1:0]    reg_value;
    logic                closes_frame;
    logic [CountW-1:0]   frame_count;
  } result_t;

  typedef struct packed {
    logic full;
    logic nonempty;
  } q_status_t;

endpackage

// ----- src/regdec_front.sv -----
// Front end: accepts stream beats, tracks parse phase and mask, builds results.
// Depends on regdec_pkg; pushes results into regdec_queue.
module regdec_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [regdec_pkg::ByteW-1:0] in_data_byte,
  input  logic                      in_stream_end,
  input  regdec_pkg::q_status_t     q_stat,
  output logic                      push,
  output regdec_pkg::result_t       push_data
);
  import regdec_pkg::*;

  phase_t               phase_r, phase_nxt;
  logic [ByteW-1:0]     mask_high_r, mask_high_nxt;
  logic [NumRegs-1:0]   pending_r, pending_nxt;

  logic                 accept;
  logic                 has_result;
  logic [MaskW-1:0]     mask_full;
  logic [NumRegs-1:0]   mask_new;
  logic [NumRegs-1:0]   low_bit;
  logic [NumRegs-1:0]   pending_left;
  logic [IdxW-1:0]      hit_idx;

  assign in_ready  = !q_stat.full;
  assign accept    = in_valid && in_ready;
  assign mask_full = {mask_high_r, in_data_byte};
  assign mask_new  = mask_full[NumRegs-1:0];

  // lowest pending register
  assign low_bit      = pending_r & (~pending_r + NumRegs'(1));
  assign pending_left = pending_r & ~low_bit;

  always_comb begin
    hit_idx = '0;
    for (int i = NumRegs - 1; i >= 0; i--) begin
      if (pending_r[i]) begin
        hit_idx = IdxW'(i);
      end
    end
  end

  // next state
  always_comb begin
    phase_nxt     = phase_r;
    mask_high_nxt = mask_high_r;
    pending_nxt   = pending_r;
    if (accept) begin
      if (in_stream_end) begin
        phase_nxt     = PH_CMD;
        mask_high_nxt = '0;
        pending_nxt   = '0;
      end else begin
        case (phase_r)
          PH_CMD: begin
            if (in_data_byte == CMD_SKIP) begin
              phase_nxt = PH_SKIP;
            end else if (in_data_byte != CMD_EMPTY) begin
              mask_high_nxt = in_data_byte;
              phase_nxt     = PH_MASKL;
            end
          end
          PH_SKIP: begin
            phase_nxt = PH_CMD;
          end
          PH_MASKL: begin
            mask_high_nxt = '0;
            pending_nxt   = mask_new;
            phase_nxt     = (mask_new == '0) ? PH_CMD : PH_VALS;
          end
          PH_VALS: begin
            pending_nxt = pending_left;
            if (pending_left == '0) begin
              phase_nxt = PH_CMD;
            end
          end
          default: begin
            phase_nxt = PH_CMD;
          end
        endcase
      end
    end
  end

  // result per beat
  always_comb begin
    has_result = 1'b0;
    push_data  = '{kind: KIND_WRITE, reg_index: '0, reg_value: '0,
                   closes_frame: 1'b0, frame_count: '0};
    if (in_stream_end) begin
      has_result     = 1'b1;
      push_data.kind = KIND_END;
    end else begin
      case (phase_r)
        PH_CMD: begin
          if (in_data_byte == CMD_EMPTY) begin
            has_result            = 1'b1;
            push_data.kind        = KIND_BOUND;
            push_data.frame_count = FRAME_ONE;
          end
        end
        PH_SKIP: begin
          has_result            = 1'b1;
          push_data.kind        = KIND_BOUND;
          push_data.frame_count = (in_data_byte == '0) ? SKIP_WRAP
                                                        : {1'b0, in_data_byte};
        end
        PH_MASKL: begin
          if (mask_new == '0) begin
            has_result            = 1'b1;
            push_data.kind        = KIND_BOUND;
            push_data.frame_count = FRAME_ONE;
          end
        end
        PH_VALS: begin
          // empty pending mask falls out as register 0, frame closed
          has_result             = 1'b1;
          push_data.kind         = KIND_WRITE;
          push_data.reg_index    = hit_idx;
          push_data.reg_value    = in_data_byte;
          push_data.closes_frame = (pending_left == '0);
        end
        default: begin
          has_result = 1'b0;
        end
      endcase
    end
  end

  assign push = accept && has_result;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r     <= PH_CMD;
      mask_high_r <= '0;
      pending_r   <= '0;
    end else begin
      phase_r     <= phase_nxt;
      mask_high_r <= mask_high_nxt;
      pending_r   <= pending_nxt;
    end
  end

endmodule

// ----- src/regdec_queue.sv -----
// Two-entry result queue between the parser and the output stage.
// Depends on regdec_pkg and the assertion macro header.
`include "register_stream_frame_decoder_assert.svh"

module regdec_queue (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  input  regdec_pkg::result_t   push_data,
  input  logic                  pop,
  output regdec_pkg::result_t   pop_data,
  output regdec_pkg::q_status_t q_stat
);
  import regdec_pkg::*;

  result_t           entry_r [QDepth];
  logic [QPtrW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPtrW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [QCntW-1:0]  count_r, count_nxt;

  assign pop_data        = entry_r[rd_ptr_r];
  assign q_stat.full     = (count_r == QCntW'(QDepth));
  assign q_stat.nonempty = (count_r != '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == QPtrW'(QDepth - 1)) ? '0 : wr_ptr_r + QPtrW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == QPtrW'(QDepth - 1)) ? '0 : rd_ptr_r + QPtrW'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + QCntW'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - QCntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_data;
    end
  end

  `RSD_ASSERT_IMPLIES(a_q_no_overflow, push, count_r != QCntW'(QDepth), "queue push while full")
  `RSD_ASSERT_IMPLIES(a_q_no_underflow, pop, count_r != '0, "queue pop while empty")
  `RSD_ASSERT_NEXT(a_q_pop_count, pop && !push, count_r == $past(count_r) - QCntW'(1), "queue count off after pop")
  `RSD_ASSERT_NEXT(a_q_push_count, push && !pop, count_r == $past(count_r) + QCntW'(1), "queue count off after push")
  `RSD_ASSERT_ALWAYS(a_q_bound, count_r <= QCntW'(QDepth), "queue count beyond depth")

endmodule

// ----- src/regdec_back.sv -----
// Back end: pulls results from the queue into the output register.
// Depends on regdec_pkg; drives the result channel of the top level.
module regdec_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  regdec_pkg::q_status_t     q_stat,
  input  regdec_pkg::result_t       pop_data,
  output logic                      pop,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [regdec_pkg::KindW-1:0]  out_result_kind,
  output logic [regdec_pkg::IdxW-1:0]   out_reg_index,
  output logic [regdec_pkg::ByteW-1:0]  out_reg_value,
  output logic                      out_closes_frame,
  output logic [regdec_pkg::CountW-1:0] out_frame_count
);
  import regdec_pkg::*;

  logic    out_valid_r, out_valid_nxt;
  result_t out_data_r;

  // load when the register is empty or its beat leaves this cycle
  assign pop = q_stat.nonempty && (!out_valid_r || out_ready);

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_data_r <= pop_data;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_result_kind  = out_data_r.kind;
  assign out_reg_index    = out_data_r.reg_index;
  assign out_reg_value    = out_data_r.reg_value;
  assign out_closes_frame = out_data_r.closes_frame;
  assign out_frame_count  = out_data_r.frame_count;

endmodule

// ----- src/register_stream_frame_decoder.sv -----
// Top level of the register stream frame decoder: front parser, queue, output stage.
// Depends on regdec_pkg, regdec_front, regdec_queue and regdec_back.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+-------------------------------------
//  in_     | input     | in_valid / in_ready   | data_byte[8], stream_end[1]
//  out_    | output    | out_valid / out_ready | result_kind, reg_index, reg_value,
//          |           |                       | closes_frame, frame_count
//
// One byte beat per cycle while in_ready is high; out_valid follows via queue and output register.
// Bytes that close no result (skip command, mask high byte, nonzero mask low) leave nothing in the queue.
// in_ready drops only when the two-entry queue is full, i.e. after out_ready stalls;
// it comes back the cycle after the next pop.
// rst_n is synchronous, active low; it clears parse phase, mask and queue.
module register_stream_frame_decoder (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [regdec_pkg::ByteW-1:0]  in_data_byte,
  input  logic                          in_stream_end,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [regdec_pkg::KindW-1:0]  out_result_kind,
  output logic [regdec_pkg::IdxW-1:0]   out_reg_index,
  output logic [regdec_pkg::ByteW-1:0]  out_reg_value,
  output logic                          out_closes_frame,
  output logic [regdec_pkg::CountW-1:0] out_frame_count
);
  import regdec_pkg::*;

  q_status_t q_stat;
  logic      push;
  logic      pop;
  result_t   push_data;
  result_t   pop_data;

  regdec_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data_byte  (in_data_byte),
    .in_stream_end (in_stream_end),
    .q_stat        (q_stat),
    .push          (push),
    .push_data     (push_data)
  );

  regdec_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .pop       (pop),
    .pop_data  (pop_data),
    .q_stat    (q_stat)
  );

  regdec_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_stat           (q_stat),
    .pop_data         (pop_data),
    .pop              (pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_kind  (out_result_kind),
    .out_reg_index    (out_reg_index),
    .out_reg_value    (out_reg_value),
    .out_closes_frame (out_closes_frame),
    .out_frame_count  (out_frame_count)
  );

endmodule
